[hdl/rfc_pkg.sv]
// shared types and constants for the co2 response frame checker
// no dependencies; imported by rfc_ctrl, rfc_datapath and the top level
`default_nettype none

package rfc_pkg;

  localparam int BYTE_W     = 8;
  localparam int READ_W     = 16;
  localparam int OC_W       = 3;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h16;

  // outcome codes
  localparam logic [OC_W-1:0] OC_OK     = 3'd0;
  localparam logic [OC_W-1:0] OC_HEADER = 3'd1;
  localparam logic [OC_W-1:0] OC_CSUM   = 3'd2;
  localparam logic [OC_W-1:0] OC_ZERO   = 3'd3;
  localparam logic [OC_W-1:0] OC_WARM   = 3'd4;
  localparam logic [OC_W-1:0] OC_LENGTH = 3'd5;

  // sensor status codes
  localparam logic [ST_W-1:0] ST_NONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_WARM    = 2'd1;
  localparam logic [ST_W-1:0] ST_STARTED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SECONDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MARKER  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WARMUP_SECONDS_RST = 16'd130;
  localparam logic [CFG_DATA_W-1:0] WARMUP_MARKER_RST  = 16'd550;

  typedef struct packed {
    logic capture;   // latch the input byte
    logic commit;    // apply the latched byte to the frame state
    logic div_run;   // one quotient bit of the average
    logic finish;    // load the average into the result register
  } rfc_cmd_t;

  typedef struct packed {
    logic has_result;
    logic need_div;
    logic div_done;
  } rfc_stat_t;

endpackage

`default_nettype wire

[hdl/rfc_ctrl.sv]
// controller state machine of the co2 response frame checker
// depends on rfc_pkg; drives the handshakes and the datapath commands
`default_nettype none

module rfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rfc_pkg::rfc_cmd_t cmd,
  input  rfc_pkg::rfc_stat_t stat
);
  import rfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   slot_free;
  logic   can_commit;

  // a byte that yields a result waits until the result register is free
  assign slot_free  = !out_valid || out_ready;
  assign can_commit = !stat.has_result || slot_free;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = stat.need_div ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish || (cmd.commit && stat.has_result && !stat.need_div)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/rfc_datapath.sv]
// datapath of the co2 response frame checker: frame parser, averaging
// window, bit-serial divider and result register; depends on rfc_pkg
`default_nettype none

module rfc_datapath #(
  parameter int AVG_DEPTH = 2,
  parameter int MAX_REPLY = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rfc_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                           first_byte,
  input  logic [rfc_pkg::READ_W-1:0]     uptime_s,
  input  logic                           cfg_we,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rfc_pkg::rfc_cmd_t              cmd,
  output rfc_pkg::rfc_stat_t             stat,
  output logic [rfc_pkg::OC_W-1:0]       outcome,
  output logic [rfc_pkg::READ_W-1:0]     co2_average,
  output logic [rfc_pkg::READ_W-1:0]     raw_reading,
  output logic                           status_changed,
  output logic [rfc_pkg::ST_W-1:0]       sensor_status
);
  import rfc_pkg::*;

  localparam int POS_W   = $clog2(MAX_REPLY);
  localparam int PTR_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W  = $clog2(AVG_DEPTH + 1);
  localparam int TOTAL_W = READ_W + $clog2(AVG_DEPTH);
  localparam int CNT_W   = $clog2(TOTAL_W + 1);

  // latched input byte
  logic [BYTE_W-1:0] b;
  logic              first;
  logic [READ_W-1:0] up;

  // configuration
  logic [CFG_DATA_W-1:0] warmup_seconds;
  logic [CFG_DATA_W-1:0] warmup_marker;

  // frame state
  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] len;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] hi;
  logic [BYTE_W-1:0] lo;
  logic              skip;
  logic [ST_W-1:0]   cur_status;

  // averaging window
  logic [READ_W-1:0]  win [AVG_DEPTH];
  logic [PTR_W-1:0]   ptr;
  logic [FILL_W-1:0]  fill;
  logic [TOTAL_W-1:0] total;

  // divider
  logic [TOTAL_W-1:0] quot;
  logic [FILL_W-1:0]  rem;
  logic [CNT_W-1:0]   cnt;
  logic [FILL_W:0]    rem_sh;
  logic               rem_ge;

  // decode
  logic [READ_W-1:0]  reading;
  logic               len_bad;
  logic               in_body;
  logic               csum_ok;
  logic               warm;
  logic               has_result;
  logic               at_csum;
  logic [OC_W-1:0]    oc;
  logic               sets_status;
  logic [ST_W-1:0]    new_status;
  logic               full;
  logic [TOTAL_W-1:0] total_next;
  logic [FILL_W-1:0]  fill_next;
  logic [PTR_W-1:0]   ptr_next;

  assign reading = {hi, lo};
  assign len_bad = (({1'b0, b} + 9'd3) > 9'(MAX_REPLY)) || (b < 8'd3);
  assign in_body = (9'(pos) < ({1'b0, len} + 9'd2));
  assign csum_ok = (8'(b + sum) == 8'h00);
  assign warm    = (up < warmup_seconds) && (reading == warmup_marker);

  always_comb begin
    has_result = 1'b0;
    at_csum    = 1'b0;
    oc         = OC_OK;
    if (first) begin
      if (b != HDR_BYTE) begin
        has_result = 1'b1;
        oc         = OC_HEADER;
      end
    end else if (!skip) begin
      if (pos == POS_W'(1)) begin
        if (len_bad) begin
          has_result = 1'b1;
          oc         = OC_LENGTH;
        end
      end else if (!in_body) begin
        has_result = 1'b1;
        at_csum    = 1'b1;
        if (!csum_ok) begin
          oc = OC_CSUM;
        end else if (reading == '0) begin
          oc = OC_ZERO;
        end else if (warm) begin
          oc = OC_WARM;
        end else begin
          oc = OC_OK;
        end
      end
    end
  end

  assign sets_status = at_csum && ((oc == OC_WARM) || (oc == OC_OK));
  assign new_status  = (oc == OC_WARM) ? ST_WARM : ST_STARTED;

  assign stat.has_result = has_result;
  assign stat.need_div   = at_csum && (oc == OC_OK);
  assign stat.div_done   = (cnt == '0);

  // window update for an accepted reading
  assign full       = (fill >= FILL_W'(AVG_DEPTH));
  assign total_next = total - (full ? TOTAL_W'(win[ptr]) : '0) + TOTAL_W'(reading);
  assign fill_next  = full ? fill : fill + FILL_W'(1);
  assign ptr_next   = (ptr == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem, quot[TOTAL_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, fill});

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_seconds <= WARMUP_SECONDS_RST;
      warmup_marker  <= WARMUP_MARKER_RST;
      pos            <= '0;
      len            <= '0;
      sum            <= '0;
      hi             <= '0;
      lo             <= '0;
      skip           <= 1'b1;
      cur_status     <= ST_NONE;
      ptr            <= '0;
      fill           <= '0;
      total          <= '0;
      cnt            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WARMUP_SECONDS: warmup_seconds <= cfg_data;
          CFG_WARMUP_MARKER:  warmup_marker  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (first) begin
          len <= '0;
          hi  <= '0;
          lo  <= '0;
          if (b != HDR_BYTE) begin
            skip <= 1'b1;
            sum  <= '0;
            pos  <= '0;
          end else begin
            skip <= 1'b0;
            sum  <= b;
            pos  <= POS_W'(1);
          end
        end else if (!skip) begin
          if (pos == POS_W'(1)) begin
            len <= b;
            if (len_bad) begin
              skip <= 1'b1;
            end else begin
              sum <= 8'(sum + b);
              pos <= POS_W'(2);
            end
          end else if (in_body) begin
            if (pos == POS_W'(3)) hi <= b;
            if (pos == POS_W'(4)) lo <= b;
            sum <= 8'(sum + b);
            pos <= pos + POS_W'(1);
          end else begin
            skip <= 1'b1;
            if (sets_status) cur_status <= new_status;
            if (stat.need_div) begin
              total <= total_next;
              fill  <= fill_next;
              ptr   <= ptr_next;
              cnt   <= CNT_W'(TOTAL_W);
            end
          end
        end
      end else if (cmd.div_run) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b     <= rx_byte;
      first <= first_byte;
      up    <= uptime_s;
    end
    if (cmd.commit && stat.need_div) begin
      win[ptr] <= reading;
      quot     <= total_next;
      rem      <= '0;
    end else if (cmd.div_run) begin
      rem  <= rem_ge ? FILL_W'(rem_sh - {1'b0, fill}) : FILL_W'(rem_sh);
      quot <= {quot[TOTAL_W-2:0], rem_ge};
    end
    if (cmd.commit && has_result) begin
      outcome        <= oc;
      raw_reading    <= at_csum ? reading : '0;
      co2_average    <= '0;
      status_changed <= sets_status && (cur_status != new_status);
      sensor_status  <= sets_status ? new_status : cur_status;
    end else if (cmd.finish) begin
      co2_average <= quot[READ_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/co2_response_frame_checker.sv]
// a transferred byte is latched, then applied to the frame state and the result register;
//   an accepted reading then runs the bit-serial divider before the average is loaded
// one byte is taken at a time: no new byte is accepted until the last one is through,
//   and a byte with a result stalls while the last result waits
// reset: control state cleared, registers back to 130 s and 550, waiting for a first byte
`default_nettype none

module co2_response_frame_checker #(
  parameter int AVG_DEPTH = 2,
  parameter int MAX_REPLY = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  // input byte channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rfc_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                           first_byte,
  input  logic [rfc_pkg::READ_W-1:0]     uptime_s,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rfc_pkg::OC_W-1:0]       outcome,
  output logic [rfc_pkg::READ_W-1:0]     co2_average,
  output logic [rfc_pkg::READ_W-1:0]     raw_reading,
  output logic                           status_changed,
  output logic [rfc_pkg::ST_W-1:0]       sensor_status,
  // register write port
  input  logic                           cfg_we,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rfc_pkg::*;

  // commands from the controller, status back from the datapath
  rfc_cmd_t  cmd;
  rfc_stat_t stat;

  // controller: takes one byte, holds it while the datapath applies it,
  // and waits on the divider for an accepted reading
  rfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: frame parser, checksum, window sum and divider; the result
  // register lets the next byte transfer while a result still waits
  rfc_datapath #(
    .AVG_DEPTH (AVG_DEPTH),
    .MAX_REPLY (MAX_REPLY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .first_byte     (first_byte),
    .uptime_s       (uptime_s),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .outcome        (outcome),
    .co2_average    (co2_average),
    .raw_reading    (raw_reading),
    .status_changed (status_changed),
    .sensor_status  (sensor_status)
  );

  // one byte at a time: in the cycle after a transfer the block is not ready
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a byte is in work");

  // an accepted reading always leaves the sensor started
  a_ok_started: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == OC_OK) |-> (sensor_status == ST_STARTED))
    else $error("accepted reading without started status");

  // header and length rejects carry no reading, average or status change
  a_early_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OC_HEADER || outcome == OC_LENGTH)) |->
      (raw_reading == '0 && co2_average == '0 && !status_changed))
    else $error("early reject carries data");

  // a result never appears while the divider still runs
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    cmd.div_run |-> !out_valid)
    else $error("result shown during division");

endmodule

`default_nettype wire
